### rtl/core/gwsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwsa_pkg
// Shared types and field widths of the greedy weighted slot assigner.
// ----------------------------------------------------------------------------
package gwsa_pkg;

    localparam int W_W = 31;
    localparam int S_W = 11;
    localparam int P_W = 42;
    localparam int C_W = 11;

    typedef struct packed {
        logic [W_W-1:0] weight;
        logic [S_W-1:0] min_slot;
        logic           last;
        logic           keep;
    } gwsa_req_t;

endpackage
`default_nettype wire

### rtl/core/gwsa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwsa_front
// Accepts requests, counts the set and marks requests beyond capacity as dropped.
// ----------------------------------------------------------------------------
module gwsa_front #(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       q_full,
    input  wire logic [gwsa_pkg::W_W-1:0]   weight,
    input  wire logic [gwsa_pkg::S_W-1:0]   min_slot,
    input  wire logic                       last,
    output logic                            busy,
    output logic                            push,
    output gwsa_pkg::gwsa_req_t             push_req
);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          keep;

    assign busy = q_full;
    assign push = start && !q_full;
    assign keep = (cnt_reg < CW'(MAX_ITEMS));

    always_comb
    begin
        push_req.weight   = weight;
        push_req.min_slot = min_slot;
        push_req.last     = last;
        push_req.keep     = keep;
        cnt_next = cnt_reg;
        if (push)
        begin
            if (last)
                cnt_next = '0;
            else if (keep)
                cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule
`default_nettype wire

### rtl/core/gwsa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwsa_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module gwsa_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire gwsa_pkg::gwsa_req_t  push_req,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      empty,
    output gwsa_pkg::gwsa_req_t       head
);
    gwsa_pkg::gwsa_req_t ent_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = ent_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_reg] <= push_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/gwsa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwsa_back
// Stores the set, then picks requests by descending weight and slot and
// searches the free map for each.
// ----------------------------------------------------------------------------
module gwsa_back #(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_empty,
    input  wire gwsa_pkg::gwsa_req_t        head,
    output logic                            pop,
    output logic                            done,
    output logic [gwsa_pkg::P_W-1:0]        penalty_total,
    output logic [gwsa_pkg::C_W-1:0]        placed_count
);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int XW = (CW > gwsa_pkg::S_W) ? CW : gwsa_pkg::S_W;
    localparam int WW = gwsa_pkg::W_W;
    localparam int SW = gwsa_pkg::S_W;
    localparam int PW = gwsa_pkg::P_W;

    typedef enum logic [5:0] {
        ST_LOAD = 6'b000001,
        ST_INIT = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_MARK = 6'b001000,
        ST_SRCH = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    logic [WW-1:0] weight_mem [MAX_ITEMS];
    logic [SW-1:0] slot_mem   [MAX_ITEMS];
    logic          done_mem   [MAX_ITEMS];
    logic          free_mem   [MAX_ITEMS];

    state_t        state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] round_reg, round_next;
    logic [CW-1:0] placed_reg, placed_next;
    logic [PW-1:0] pen_reg, pen_next;
    logic          p_vld_reg, p_vld_next;
    logic [CW-1:0] p_idx_reg, p_idx_next;
    logic          best_vld_reg, best_vld_next;
    logic [WW-1:0] best_w_reg, best_w_next;
    logic [SW-1:0] best_s_reg, best_s_next;
    logic [CW-1:0] best_i_reg, best_i_next;

    logic [WW-1:0] w_rd_reg;
    logic [SW-1:0] s_rd_reg;
    logic          d_rd_reg;
    logic          f_rd_reg;

    logic          ld_we;
    logic          d_we, d_wd;
    logic [AW-1:0] d_wa;
    logic          f_we, f_wd;
    logic [AW-1:0] f_wa;
    logic [SW-1:0] s1;
    logic          next_round;

    assign done          = (state_reg == ST_EMIT);
    assign penalty_total = pen_reg;
    assign placed_count  = gwsa_pkg::C_W'(placed_reg);
    assign s1            = (best_s_reg == '0) ? SW'(1) : best_s_reg;

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        ptr_next      = ptr_reg;
        round_next    = round_reg;
        placed_next   = placed_reg;
        pen_next      = pen_reg;
        p_vld_next    = 1'b0;
        p_idx_next    = ptr_reg;
        best_vld_next = best_vld_reg;
        best_w_next   = best_w_reg;
        best_s_next   = best_s_reg;
        best_i_next   = best_i_reg;
        pop           = 1'b0;
        ld_we         = 1'b0;
        d_we          = 1'b0;
        d_wd          = 1'b0;
        d_wa          = ptr_reg[AW-1:0];
        f_we          = 1'b0;
        f_wd          = 1'b0;
        f_wa          = ptr_reg[AW-1:0];
        next_round    = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (!q_empty)
                begin
                    pop   = 1'b1;
                    ld_we = head.keep;
                    if (head.keep)
                        n_next = n_reg + CW'(1);
                    if (head.last)
                    begin
                        ptr_next   = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                d_we = 1'b1;
                f_we = 1'b1;
                f_wd = (ptr_reg != '0);
                ptr_next = ptr_reg + CW'(1);
                if (ptr_reg == n_reg - CW'(1))
                begin
                    ptr_next      = '0;
                    round_next    = '0;
                    placed_next   = '0;
                    pen_next      = '0;
                    best_vld_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ptr_reg < n_reg)
                begin
                    p_vld_next = 1'b1;
                    ptr_next   = ptr_reg + CW'(1);
                end
                if (p_vld_reg)
                begin
                    if (!d_rd_reg && (!best_vld_reg || (w_rd_reg > best_w_reg) ||
                        ((w_rd_reg == best_w_reg) && (s_rd_reg > best_s_reg))))
                    begin
                        best_vld_next = 1'b1;
                        best_w_next   = w_rd_reg;
                        best_s_next   = s_rd_reg;
                        best_i_next   = p_idx_reg;
                    end
                    if (p_idx_reg == n_reg - CW'(1))
                    begin
                        p_vld_next = 1'b0;
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                d_we = 1'b1;
                d_wd = 1'b1;
                d_wa = best_i_reg[AW-1:0];
                if (XW'(s1) >= XW'(n_reg))
                begin
                    pen_next   = pen_reg + PW'(best_w_reg);
                    next_round = 1'b1;
                end
                else
                begin
                    ptr_next   = CW'(XW'(s1));
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (ptr_reg < n_reg)
                begin
                    p_vld_next = 1'b1;
                    ptr_next   = ptr_reg + CW'(1);
                end
                if (p_vld_reg)
                begin
                    if (f_rd_reg)
                    begin
                        f_we        = 1'b1;
                        f_wa        = p_idx_reg[AW-1:0];
                        placed_next = placed_reg + CW'(1);
                        p_vld_next  = 1'b0;
                        next_round  = 1'b1;
                    end
                    else if (p_idx_reg == n_reg - CW'(1))
                    begin
                        pen_next   = pen_reg + PW'(best_w_reg);
                        p_vld_next = 1'b0;
                        next_round = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                n_next     = '0;
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (next_round)
        begin
            round_next    = round_reg + CW'(1);
            ptr_next      = '0;
            best_vld_next = 1'b0;
            state_next    = (round_reg == n_reg - CW'(1)) ? ST_EMIT : ST_SCAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            weight_mem[n_reg[AW-1:0]] <= head.weight;
            slot_mem[n_reg[AW-1:0]]   <= head.min_slot;
        end
        if (d_we)
            done_mem[d_wa] <= d_wd;
        if (f_we)
            free_mem[f_wa] <= f_wd;
        w_rd_reg <= weight_mem[ptr_reg[AW-1:0]];
        s_rd_reg <= slot_mem[ptr_reg[AW-1:0]];
        d_rd_reg <= done_mem[ptr_reg[AW-1:0]];
        f_rd_reg <= free_mem[ptr_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        best_w_reg <= best_w_next;
        best_s_reg <= best_s_next;
        best_i_reg <= best_i_next;
        p_idx_reg  <= p_idx_next;
        pen_reg    <= pen_next;
        placed_reg <= placed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            n_reg        <= '0;
            ptr_reg      <= '0;
            round_reg    <= '0;
            p_vld_reg    <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            ptr_reg      <= ptr_next;
            round_reg    <= round_next;
            p_vld_reg    <= p_vld_next;
            best_vld_reg <= best_vld_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/greedy_weighted_slot_assigner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_weighted_slot_assigner
// Loads a set of requests, then assigns slots greedily by descending weight.
// ----------------------------------------------------------------------------
// Usage:
//   A request (weight, min_slot, last) is taken when start is high and busy
//   is low. Requests load at one per cycle through a two-entry queue; busy
//   rises only while the queue is full, which happens only during compute.
//   The request with last set closes the set of n stored requests (requests
//   beyond MAX_ITEMS are dropped but last still closes the set).
//   After the last request the free and done maps are initialised, then
//   each of n rounds runs a selection scan over the stored requests plus
//   a free slot search.
//   The result (penalty_total, placed_count) is shown for one cycle with
//   done high; it cannot be held off. Reset returns to loading an empty set.
//   The next set's requests may be queued while a result is pending.
// ----------------------------------------------------------------------------
module greedy_weighted_slot_assigner #(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [gwsa_pkg::W_W-1:0]   weight,
    input  wire logic [gwsa_pkg::S_W-1:0]   min_slot,
    input  wire logic                       last,
    output logic                            done,
    output logic [gwsa_pkg::P_W-1:0]        penalty_total,
    output logic [gwsa_pkg::C_W-1:0]        placed_count
);
    gwsa_pkg::gwsa_req_t push_req, head;
    logic push, pop, q_full, q_empty;

    gwsa_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .q_full   (q_full),
        .weight   (weight),
        .min_slot (min_slot),
        .last     (last),
        .busy     (busy),
        .push     (push),
        .push_req (push_req)
    );

    gwsa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    gwsa_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .head          (head),
        .pop           (pop),
        .done          (done),
        .penalty_total (penalty_total),
        .placed_count  (placed_count)
    );

endmodule
`default_nettype wire

### rtl/core/gwsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwsa_checker
// Port-level checks on the slot assigner.
// ----------------------------------------------------------------------------
module gwsa_checker (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     busy,
    input wire logic                     done,
    input wire logic [gwsa_pkg::P_W-1:0] penalty_total,
    input wire logic [gwsa_pkg::C_W-1:0] placed_count
);
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_busy_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(busy))
        else $error("busy unknown");

    a_done_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(done))
        else $error("done unknown");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({penalty_total, placed_count}))
        else $error("result unknown while done");

endmodule

bind greedy_weighted_slot_assigner gwsa_checker u_gwsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .done          (done),
    .penalty_total (penalty_total),
    .placed_count  (placed_count)
);
`default_nettype wire
